@@ rtl/kvs_pkg.sv @@
// -----------------------------------------------------------------------------
// kvs_pkg
// Shared types, codes and helpers for the keyed variable store.
// -----------------------------------------------------------------------------
package kvs_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 256;
  localparam logic [7:0]  QUALITY_ABSENT      = 8'hFF;

  // Item commands.
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_ADD     = 3'd1;
  localparam logic [2:0] CMD_WRITE   = 3'd2;
  localparam logic [2:0] CMD_READ_V  = 3'd3;
  localparam logic [2:0] CMD_READ_Q  = 3'd4;

  // Result status codes.
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_NOT_FOUND  = 3'd1;
  localparam logic [2:0] STS_BAD_FORMAT = 3'd2;
  localparam logic [2:0] STS_FULL       = 3'd3;
  localparam logic [2:0] STS_DUPLICATE  = 3'd4;

  // Format codes.
  localparam logic [3:0] FMT_BOOL = 4'd0;
  localparam logic [3:0] FMT_CHAR = 4'd1;
  localparam logic [3:0] FMT_U16  = 4'd2;
  localparam logic [3:0] FMT_S16  = 4'd3;
  localparam logic [3:0] FMT_U32  = 4'd4;
  localparam logic [3:0] FMT_S32  = 4'd5;
  localparam logic [3:0] FMT_F32  = 4'd6;
  localparam logic [3:0] FMT_S64  = 4'd7;
  localparam logic [3:0] FMT_F64  = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SHIFT,
    ST_APPLY
  } kvs_state_t;

  // One table entry held by a cell.
  typedef struct packed {
    logic        valid;
    logic [14:0] id;
    logic [3:0]  fmt;
    logic [63:0] value;
    logic [7:0]  quality;
  } entry_t;

  // Search result travelling down the chain towards cell zero.
  typedef struct packed {
    logic        found;
    logic [63:0] value;
    logic [7:0]  quality;
  } hit_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic        load;
    logic        shift;
    logic        insert;
    logic        write;
    logic        clear;
    logic [14:0] key;
    logic [3:0]  fmt;
    logic [63:0] value;
    logic [7:0]  quality;
  } cell_ctl_t;

  // Byte mask that a format keeps; zero for an unknown format.
  function automatic logic [63:0] fmt_mask(input logic [3:0] fmt);
    logic [63:0] m;
    case (fmt)
      FMT_BOOL, FMT_CHAR:          m = 64'h0000_0000_0000_00FF;
      FMT_U16, FMT_S16:            m = 64'h0000_0000_0000_FFFF;
      FMT_U32, FMT_S32, FMT_F32:   m = 64'h0000_0000_FFFF_FFFF;
      FMT_S64, FMT_F64:            m = 64'hFFFF_FFFF_FFFF_FFFF;
      default:                     m = 64'h0;
    endcase
    return m;
  endfunction

  function automatic logic fmt_ok(input logic [3:0] fmt);
    return fmt <= FMT_F64;
  endfunction

endpackage

@@ rtl/kvs_in_if.sv @@
// -----------------------------------------------------------------------------
// kvs_in_if
// Request channel: one item per valid/ready handshake.
// -----------------------------------------------------------------------------
interface kvs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [14:0] var_id;
  logic [3:0]  var_format;
  logic [63:0] value_in;
  logic [7:0]  quality_in;

  modport source (output valid, cmd, var_id, var_format, value_in, quality_in,
                  input ready);
  modport sink (input valid, cmd, var_id, var_format, value_in, quality_in,
                output ready);
endinterface

@@ rtl/kvs_out_if.sv @@
// -----------------------------------------------------------------------------
// kvs_out_if
// Result channel: one item per valid/ready handshake.
// -----------------------------------------------------------------------------
interface kvs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] value_out;
  logic [7:0]  quality_out;
  logic [8:0]  entry_count;

  modport source (output valid, status, value_out, quality_out, entry_count,
                  input ready);
  modport sink (input valid, status, value_out, quality_out, entry_count,
                output ready);
endinterface

@@ rtl/kvs_cell.sv @@
// -----------------------------------------------------------------------------
// kvs_cell
// One table slot: holds an entry, compares it with the key, shifts on insert
// and passes search hits towards cell zero.
// -----------------------------------------------------------------------------
module kvs_cell (
  input  logic               clk,
  input  logic               rst,
  input  kvs_pkg::cell_ctl_t ctl,
  input  kvs_pkg::entry_t    prev_entry,
  input  logic               prev_le,
  input  kvs_pkg::hit_t      hit_in,
  output kvs_pkg::entry_t    entry,
  output logic               le,
  output kvs_pkg::hit_t      hit
);
  import kvs_pkg::*;

  logic match;

  // Local compares against the broadcast key.
  assign le    = entry.valid && (entry.id < ctl.key);
  assign match = entry.valid && (entry.id == ctl.key);

  // Entry storage: clear, sorted insert or value write.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      entry.valid <= 1'b0;
    end else if (ctl.insert) begin
      if (prev_entry.valid && !prev_le) begin
        entry <= prev_entry;
      end else if (!le && prev_le) begin
        entry.valid   <= 1'b1;
        entry.id      <= ctl.key;
        entry.fmt     <= ctl.fmt;
        entry.value   <= '0;
        entry.quality <= '0;
      end
    end else if (ctl.write && match) begin
      entry.value   <= ctl.value & fmt_mask(entry.fmt);
      entry.quality <= ctl.quality;
    end
  end

  // Hit chain: load the local result, then merge with the right-hand neighbour.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hit.found   <= match;
      hit.value   <= match ? entry.value : '0;
      hit.quality <= match ? entry.quality : '0;
    end else if (ctl.shift) begin
      hit <= hit | hit_in;
    end
  end

endmodule

@@ rtl/keyed_variable_store_unit.sv @@
// -----------------------------------------------------------------------------
// keyed_variable_store_unit
// Sorted table of typed variables held in a chain of cells.
// -----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req channel (cmd, var_id, var_format, value_in,
//   quality_in) and each gives exactly one item on the rsp channel (status,
//   value_out, quality_out, entry_count). Both use valid/ready.
//   Each cell of the chain holds one entry; entries stay sorted by id.
//   From acceptance to its result an item passes these steps in order:
//   every cell compares with the key (ST_LOAD), a hit travels down the
//   chain to cell zero (ST_SHIFT), and the insert or write is applied and
//   the result register loaded (ST_APPLY), waiting while it is still full.
//   One item is processed at a time and the next is accepted in the cycle
//   after the result is loaded, so the item rate is set by the length of
//   the hit chain.
//   A finished result sits in the output register; the next request is
//   accepted while it waits, but a further result is held back until the
//   receiver has taken the previous one.
//   Reset empties the table at once and drops any item in flight.
// -----------------------------------------------------------------------------
module keyed_variable_store_unit #(
  parameter int unsigned TABLE_DEPTH = kvs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  kvs_in_if.sink    req,
  kvs_out_if.source rsp
);
  import kvs_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = $clog2(TABLE_DEPTH);

  kvs_state_t      state, state_next;
  logic [SW-1:0]   shift_cnt;
  logic [CW-1:0]   table_count;

  logic [2:0]  item_cmd;
  logic [14:0] item_id;
  logic [3:0]  item_fmt;
  logic [63:0] item_value;
  logic [7:0]  item_quality;

  cell_ctl_t ctl;
  entry_t    entries [TABLE_DEPTH];
  logic      les     [TABLE_DEPTH];
  hit_t      hits    [TABLE_DEPTH];

  logic        shift_done;
  logic        apply_go;
  logic        can_insert;
  logic [2:0]  res_status;
  logic [63:0] res_value;
  logic [7:0]  res_quality;

  assign shift_done = (shift_cnt == SW'(TABLE_DEPTH - 2));
  assign apply_go   = (state == ST_APPLY) && (!rsp.valid || rsp.ready);
  assign can_insert = fmt_ok(item_fmt) && !hits[0].found &&
                      (table_count != CW'(TABLE_DEPTH));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req.valid) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_SHIFT;
      ST_SHIFT: if (shift_done) state_next = ST_APPLY;
      ST_APPLY: if (apply_go) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer towards the cells and the request channel.
  always_comb begin
    req.ready   = (state == ST_IDLE);
    ctl.load    = (state == ST_LOAD);
    ctl.shift   = (state == ST_SHIFT);
    ctl.insert  = apply_go && (item_cmd == CMD_ADD) && can_insert;
    ctl.write   = apply_go && (item_cmd == CMD_WRITE) && hits[0].found;
    ctl.clear   = apply_go && (item_cmd == CMD_CLEAR);
    ctl.key     = item_id;
    ctl.fmt     = item_fmt;
    ctl.value   = item_value;
    ctl.quality = item_quality;
  end

  // State, shift counter and table count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      shift_cnt   <= '0;
      table_count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_LOAD) begin
        shift_cnt <= '0;
      end else if (state == ST_SHIFT) begin
        shift_cnt <= shift_cnt + 1'b1;
      end
      if (ctl.clear) begin
        table_count <= '0;
      end else if (ctl.insert) begin
        table_count <= table_count + 1'b1;
      end
    end
  end

  // Captured request item.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item_cmd     <= req.cmd;
      item_id      <= req.var_id;
      item_fmt     <= req.var_format;
      item_value   <= req.value_in;
      item_quality <= req.quality_in;
    end
  end

  // Chain of cells; cell zero sees an empty left neighbour that counts as below.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t pe;
    logic   pl;
    hit_t   hi;
    if (i == 0) begin : g_first
      assign pe = '0;
      assign pl = 1'b1;
    end else begin : g_rest
      assign pe = entries[i-1];
      assign pl = les[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign hi = '0;
    end else begin : g_mid
      assign hi = hits[i+1];
    end
    kvs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_entry (pe),
      .prev_le    (pl),
      .hit_in     (hi),
      .entry      (entries[i]),
      .le         (les[i]),
      .hit        (hits[i])
    );
  end

  // Result of the current item from the hit at cell zero.
  always_comb begin
    res_status  = STS_OK;
    res_value   = '0;
    res_quality = '0;
    case (item_cmd)
      CMD_ADD: begin
        if (!fmt_ok(item_fmt)) begin
          res_status = STS_BAD_FORMAT;
        end else if (hits[0].found) begin
          res_status = STS_DUPLICATE;
        end else if (table_count == CW'(TABLE_DEPTH)) begin
          res_status = STS_FULL;
        end
      end
      CMD_WRITE: begin
        if (!hits[0].found) res_status = STS_NOT_FOUND;
      end
      CMD_READ_V: begin
        if (!hits[0].found) begin
          res_status  = STS_NOT_FOUND;
          res_quality = QUALITY_ABSENT;
        end else begin
          res_value   = hits[0].value;
          res_quality = hits[0].quality;
        end
      end
      CMD_READ_Q: begin
        if (!hits[0].found) begin
          res_status  = STS_NOT_FOUND;
          res_quality = QUALITY_ABSENT;
        end else begin
          res_quality = hits[0].quality;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (apply_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp.status      <= res_status;
      rsp.value_out   <= res_value;
      rsp.quality_out <= res_quality;
      if (item_cmd == CMD_CLEAR) begin
        rsp.entry_count <= '0;
      end else if ((item_cmd == CMD_ADD) && can_insert) begin
        rsp.entry_count <= 9'(table_count + 1'b1);
      end else begin
        rsp.entry_count <= 9'(table_count);
      end
    end
  end

endmodule

@@ tb/sv/kvs_table_checker.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// kvs_table_checker
// Watches the request and result channels of the keyed variable store, keeps
// its own sorted table, predicts the result of every accepted request item
// and compares each result item field by field with the oldest prediction.
// -----------------------------------------------------------------------------
module kvs_table_checker #(
  parameter int unsigned TABLE_DEPTH = kvs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  kvs_in_if    req,
  kvs_out_if   rsp,
  output int   errors,
  output int   outstanding
);
  import kvs_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [63:0] value;
    logic [7:0]  quality;
    logic [8:0]  count;
  } kvs_result_t;

  // Shadow copy of the table.
  logic [14:0] shadow_ids [TABLE_DEPTH];
  logic [3:0]  shadow_fmt [TABLE_DEPTH];
  logic [63:0] shadow_val [TABLE_DEPTH];
  logic [7:0]  shadow_qual[TABLE_DEPTH];
  int unsigned shadow_count;

  kvs_result_t awaited_results[$];

  // Bytes kept by a format; zero marks an unknown format.
  function automatic logic [63:0] kept_bytes(input logic [3:0] f);
    int unsigned nbytes;
    if (f == FMT_BOOL || f == FMT_CHAR) nbytes = 1;
    else if (f == FMT_U16 || f == FMT_S16) nbytes = 2;
    else if (f == FMT_U32 || f == FMT_S32 || f == FMT_F32) nbytes = 4;
    else if (f == FMT_S64 || f == FMT_F64) nbytes = 8;
    else nbytes = 0;
    if (nbytes == 8) return '1;
    return (64'd1 << (nbytes * 8)) - 64'd1;
  endfunction

  // First position whose id is not below the key.
  function automatic int unsigned first_not_below(input logic [14:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (shadow_ids[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Applies one request item to the shadow table and returns its result.
  function automatic kvs_result_t apply_request(input logic [2:0] cmd,
      input logic [14:0] id, input logic [3:0] f, input logic [63:0] v,
      input logic [7:0] q);
    kvs_result_t r;
    int unsigned pos;
    bit hit;
    r.status = STS_OK;
    r.value = '0;
    r.quality = '0;
    pos = first_not_below(id);
    hit = (pos < shadow_count) && (shadow_ids[pos] == id);
    case (cmd)
      CMD_CLEAR: begin
        shadow_count = 0;
      end
      CMD_ADD: begin
        if (f > FMT_F64) r.status = STS_BAD_FORMAT;
        else if (hit) r.status = STS_DUPLICATE;
        else if (shadow_count >= TABLE_DEPTH) r.status = STS_FULL;
        else begin
          for (int unsigned k = shadow_count; k > pos; k--) begin
            shadow_ids[k] = shadow_ids[k-1];
            shadow_fmt[k] = shadow_fmt[k-1];
            shadow_val[k] = shadow_val[k-1];
            shadow_qual[k] = shadow_qual[k-1];
          end
          shadow_ids[pos] = id;
          shadow_fmt[pos] = f;
          shadow_val[pos] = '0;
          shadow_qual[pos] = '0;
          shadow_count++;
        end
      end
      CMD_WRITE: begin
        if (!hit) r.status = STS_NOT_FOUND;
        else if (shadow_fmt[pos] > FMT_F64) r.status = STS_BAD_FORMAT;
        else begin
          shadow_val[pos] = v & kept_bytes(shadow_fmt[pos]);
          shadow_qual[pos] = q;
        end
      end
      CMD_READ_V: begin
        if (!hit) begin
          r.status = STS_NOT_FOUND;
          r.quality = QUALITY_ABSENT;
        end else if (shadow_fmt[pos] > FMT_F64) r.status = STS_BAD_FORMAT;
        else begin
          r.value = shadow_val[pos] & kept_bytes(shadow_fmt[pos]);
          r.quality = shadow_qual[pos];
        end
      end
      CMD_READ_Q: begin
        if (!hit) begin
          r.status = STS_NOT_FOUND;
          r.quality = QUALITY_ABSENT;
        end else r.quality = shadow_qual[pos];
      end
      default: ;
    endcase
    r.count = shadow_count[8:0];
    return r;
  endfunction

  // Compare finished results, then predict newly accepted requests.
  always @(posedge clk) begin
    kvs_result_t want;
    if (rst) begin
      shadow_count = 0;
      awaited_results.delete();
      errors <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          if (errors < 10) $display("Unexpected result item at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          want = awaited_results.pop_front();
          if (rsp.status !== want.status || rsp.value_out !== want.value ||
              rsp.quality_out !== want.quality || rsp.entry_count !== want.count) begin
            if (errors < 10)
              $display("Mismatch at %0t: status %0d/%0d value %h/%h quality %h/%h count %0d/%0d",
                       $realtime, want.status, rsp.status, want.value, rsp.value_out,
                       want.quality, rsp.quality_out, want.count, rsp.entry_count);
            errors <= errors + 1;
          end
        end
      end
      if (req.valid && req.ready)
        awaited_results.push_back(apply_request(req.cmd, req.var_id, req.var_format,
                                                req.value_in, req.quality_in));
    end
    outstanding <= awaited_results.size();
  end

endmodule

@@ tb/sv/tb_keyed_variable_store_unit.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_keyed_variable_store_unit
// Drives directed and random request items into the keyed variable store with
// random gaps and result back-pressure; the checker beside the block judges
// every result item and this module gives the verdict.
// -----------------------------------------------------------------------------
module tb_keyed_variable_store_unit;
  import kvs_pkg::*;

  localparam int RANDOM_ITEMS = 1630;
  localparam int CYCLE_LIMIT  = 4000000;

  logic clk;
  logic rst;
  int   errors;
  int   outstanding;
  int   accepted;
  int   cycles;
  int   hold_left;
  bit   send_gaps;
  bit   take_gaps;
  logic [14:0] known_ids[$];

  kvs_in_if  req_if ();
  kvs_out_if rsp_if ();

  keyed_variable_store_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  kvs_table_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_if),
    .rsp         (rsp_if),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Long receiver hold-off, counted down here once 600 items are in.
  initial hold_left = 0;
  always @(negedge clk) begin
    if (accepted == 600 && hold_left == 0 && req_if.valid) hold_left <= 3000;
    else if (hold_left > 1) hold_left <= hold_left - 1;
  end

  // Receiver ready with random stalls.
  initial rsp_if.ready = 1'b0;
  always @(negedge clk) begin
    if (rst || hold_left > 1) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= !take_gaps || ($urandom_range(99) >= 37);
  end

  // Offers one item and waits until it is accepted.
  task automatic send_item(input logic [2:0] cmd, input logic [14:0] id,
                           input logic [3:0] f, input logic [63:0] v, input logic [7:0] q);
    while (send_gaps && $urandom_range(99) < 37) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.cmd = cmd;
    req_if.var_id = id;
    req_if.var_format = f;
    req_if.value_in = v;
    req_if.quality_in = q;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    accepted++;
    if (cmd == CMD_CLEAR) known_ids.delete();
    if (cmd == CMD_ADD) known_ids.push_back(id);
  endtask

  // Picks an id that is often present in the table.
  function automatic logic [14:0] pick_id();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 60 && known_ids.size() > 0)
      return known_ids[$urandom_range(known_ids.size() - 1)];
    if (sel < 80) return 15'($urandom_range(511));
    return 15'($urandom);
  endfunction

  initial begin
    logic [2:0]  cmd;
    logic [3:0]  f;
    int unsigned sel;
    rst = 1'b1;
    accepted = 0;
    send_gaps = 1'b1;
    take_gaps = 1'b1;
    req_if.valid = 1'b0;
    req_if.cmd = CMD_CLEAR;
    req_if.var_id = '0;
    req_if.var_format = FMT_BOOL;
    req_if.value_in = '0;
    req_if.quality_in = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every command and the duplicate, bad format and not found cases.
    send_item(CMD_CLEAR, 15'd0, FMT_BOOL, '0, '0);
    send_item(CMD_ADD, 15'd0, FMT_BOOL, '1, '1);
    send_item(CMD_ADD, 15'h7FFF, FMT_F64, '0, '0);
    send_item(CMD_ADD, 15'd0, FMT_CHAR, '0, '0);
    send_item(CMD_ADD, 15'd9, 4'd9, '0, '0);
    send_item(CMD_ADD, 15'd10, 4'd15, '0, '0);
    send_item(CMD_WRITE, 15'h7FFF, FMT_BOOL, '1, 8'hFF);
    send_item(CMD_READ_V, 15'h7FFF, FMT_BOOL, '0, '0);
    send_item(CMD_READ_Q, 15'h7FFF, FMT_BOOL, '0, '0);
    send_item(CMD_WRITE, 15'd0, FMT_F64, '1, 8'h5A);
    send_item(CMD_READ_V, 15'd0, FMT_BOOL, '0, '0);
    send_item(CMD_READ_V, 15'd5, FMT_BOOL, '0, '0);
    send_item(CMD_READ_Q, 15'd5, FMT_BOOL, '0, '0);
    send_item(CMD_WRITE, 15'd5, FMT_BOOL, '1, 8'h11);
    for (int k = 1; k <= 8; k++) send_item(CMD_ADD, 15'(100 + k), 4'(k), '0, '0);
    send_item(CMD_WRITE, 15'd102, FMT_BOOL, 64'h0123_4567_89AB_CDEF, 8'h00);
    send_item(CMD_READ_V, 15'd102, FMT_BOOL, '0, '0);
    send_item(3'd5, 15'd0, FMT_BOOL, '1, '1);
    send_item(3'd7, 15'h7FFF, 4'd15, '1, '1);
    send_item(CMD_CLEAR, 15'd0, FMT_BOOL, '0, '0);
    send_item(CMD_READ_V, 15'd0, FMT_BOOL, '0, '0);

    // Random: mostly adds early on so the table fills, then a broad mix.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_gaps = !(i >= 800 && i < 1000);
      take_gaps = !(i >= 800 && i < 1000);
      if (i == 1100) begin
        req_if.valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
      end
      sel = $urandom_range(99);
      if (i >= 200 && i < 520) cmd = (sel < 90) ? CMD_ADD : CMD_READ_V;
      else if (sel < 1) cmd = CMD_CLEAR;
      else if (sel < 4) cmd = 3'($urandom_range(7, 5));
      else if (sel < 30) cmd = CMD_ADD;
      else if (sel < 58) cmd = CMD_WRITE;
      else if (sel < 82) cmd = CMD_READ_V;
      else cmd = CMD_READ_Q;
      f = ($urandom_range(99) < 85) ? 4'($urandom_range(8)) : 4'($urandom);
      send_item(cmd, pick_id(), f, {$urandom, $urandom}, 8'($urandom));
    end
    req_if.valid = 1'b0;

    // Drain, then allow for a stray late result.
    while (outstanding != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
